/* sv/climate_limit_alarm_controller_top_defines.svh */
// Assertion macros shared by the checkers of the climate limit alarm block.
// Each macro takes a label, an antecedent and a consequent; clock and reset
// are the top level's i_clk and i_rst_n.
`ifndef CLIMATE_LIMIT_ALARM_CONTROLLER_TOP_DEFINES_SVH
`define CLIMATE_LIMIT_ALARM_CONTROLLER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle.
`define CLAC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clac check failed");

// Consequent must hold in the next cycle.
`define CLAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clac check failed");

`endif

/* sv/clac_pkg.sv */
package clac_pkg;

    // Default tuning
    localparam int DEBOUNCE_TICKS_DEF = 50;
    localparam int BLINK_CYCLES_DEF   = 5;

    // Request kinds
    typedef enum logic [1:0] {
        K_BUTTON   = 2'd0,
        K_UI_TICK  = 2'd1,
        K_SAMPLE   = 2'd2,
        K_LED_TICK = 2'd3
    } t_kind;

    // Button codes, also the bit positions of the press flags
    typedef enum logic [1:0] {
        B_NEXT = 2'd0,
        B_INC  = 2'd1,
        B_DEC  = 2'd2
    } t_button;

    // Limit selection
    typedef enum logic [1:0] {
        L_TEMP_LOW  = 2'd0,
        L_TEMP_HIGH = 2'd1,
        L_HUM_LOW   = 2'd2,
        L_HUM_HIGH  = 2'd3
    } t_limit_sel;

    // Sensor conversion: degrees*65535 = 175*raw - 45*65535, percent*65535 = 100*raw
    localparam logic [23:0]        TEMP_MUL        = 24'd175;
    localparam logic signed [24:0] TEMP_OFS_SCALED = 25'sd2949075;
    localparam logic [22:0]        HUM_MUL         = 23'd100;

    // Limit bounds and reset values
    localparam logic [5:0] TEMP_BOUND_HI  = 6'd40;
    localparam logic [6:0] HUM_BOUND_HI   = 7'd100;
    localparam logic [5:0] TEMP_LOW_RST   = 6'd18;
    localparam logic [5:0] TEMP_HIGH_RST  = 6'd24;
    localparam logic [6:0] HUM_LOW_RST    = 7'd30;
    localparam logic [6:0] HUM_HIGH_RST   = 7'd60;

    // Blink half period in milliseconds
    localparam logic [31:0] BLINK_MS = 32'd200;

    // One result item
    typedef struct packed {
        logic       red_on;
        logic       blue_on;
        logic       editing;
        t_limit_sel selected_limit;
        logic [6:0] selected_value;
    } t_result;

endpackage

/* sv/clac_core.sv */
module clac_core #(
    parameter int DEBOUNCE_TICKS = clac_pkg::DEBOUNCE_TICKS_DEF,
    parameter int BLINK_CYCLES   = clac_pkg::BLINK_CYCLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [1:0]        i_button,
    input  logic              i_return_held,
    input  logic [15:0]       i_raw_temp,
    input  logic [15:0]       i_raw_hum,
    input  logic [31:0]       i_now_ms,
    output clac_pkg::t_result o_result
);
    import clac_pkg::*;

    localparam int DebW = $clog2(DEBOUNCE_TICKS + 1);
    localparam int CycW = $clog2(BLINK_CYCLES + 1);
    localparam logic [DebW-1:0] DebLoad = DebW'(DEBOUNCE_TICKS);
    localparam logic [CycW-1:0] CycDone = CycW'(BLINK_CYCLES);

    // State
    logic signed [24:0] r_temp_scaled, n_temp_scaled;
    logic [22:0]        r_hum_scaled, n_hum_scaled;
    logic [5:0]         r_temp_low, n_temp_low, r_temp_high, n_temp_high;
    logic [6:0]         r_hum_low, n_hum_low, r_hum_high, n_hum_high;
    logic               r_edit_on, n_edit_on;
    t_limit_sel         r_edit_index, n_edit_index;
    logic [DebW-1:0]    r_debounce, n_debounce;
    logic [2:0]         r_flags, n_flags;
    logic               r_blink_on, n_blink_on;
    logic               r_blink_phase, n_blink_phase;
    logic [CycW-1:0]    r_blink_cycles, n_blink_cycles;
    logic [31:0]        r_blink_start, n_blink_start;
    logic [1:0]         r_lamp, n_lamp;

    // Datapath helpers
    logic [23:0] temp_prod;
    logic [21:0] temp_low_sc, temp_high_sc;
    logic [22:0] hum_low_sc, hum_high_sc;
    logic        alarm_t, alarm_h;
    logic [31:0] elapsed;
    logic [6:0]  sel_value;

    // Scale the limits by 65535 with a shift and subtract
    assign temp_low_sc  = {r_temp_low, 16'h0} - 22'(r_temp_low);
    assign temp_high_sc = {r_temp_high, 16'h0} - 22'(r_temp_high);
    assign hum_low_sc   = {r_hum_low, 16'h0} - 23'(r_hum_low);
    assign hum_high_sc  = {r_hum_high, 16'h0} - 23'(r_hum_high);

    assign alarm_t = (r_temp_scaled < $signed({3'b000, temp_low_sc}))
                  || (r_temp_scaled > $signed({3'b000, temp_high_sc}));
    assign alarm_h = (r_hum_scaled < hum_low_sc) || (r_hum_scaled > hum_high_sc);

    assign temp_prod = 24'(i_raw_temp) * TEMP_MUL;

    // Next state for one request
    always_comb begin
        n_temp_scaled  = r_temp_scaled;
        n_hum_scaled   = r_hum_scaled;
        n_temp_low     = r_temp_low;
        n_temp_high    = r_temp_high;
        n_hum_low      = r_hum_low;
        n_hum_high     = r_hum_high;
        n_edit_on      = r_edit_on;
        n_edit_index   = r_edit_index;
        n_debounce     = r_debounce;
        n_flags        = r_flags;
        n_blink_on     = r_blink_on;
        n_blink_phase  = r_blink_phase;
        n_blink_cycles = r_blink_cycles;
        n_blink_start  = r_blink_start;
        n_lamp         = r_lamp;
        elapsed        = '0;

        case (t_kind'(i_kind))
            K_BUTTON: begin
                // Latch the press; an unknown code is dropped
                case (i_button)
                    B_NEXT:  n_flags[B_NEXT] = 1'b1;
                    B_INC:   n_flags[B_INC]  = 1'b1;
                    B_DEC:   n_flags[B_DEC]  = 1'b1;
                    default: n_flags = r_flags;
                endcase
            end
            K_UI_TICK: begin
                if (r_debounce != '0) begin
                    n_debounce = r_debounce - DebW'(1);
                end
                // Return key: leave edit mode and block this tick
                if (i_return_held) begin
                    n_edit_on  = 1'b0;
                    n_flags    = '0;
                    n_debounce = DebLoad;
                end
                if (n_debounce == '0 && n_flags[B_NEXT]) begin
                    n_edit_on        = 1'b1;
                    n_edit_index     = t_limit_sel'(r_edit_index + 2'd1);
                    n_debounce       = DebLoad;
                    n_flags[B_NEXT]  = 1'b0;
                end else if (n_debounce == '0 && n_edit_on && n_flags[B_INC]) begin
                    n_debounce     = DebLoad;
                    n_flags[B_INC] = 1'b0;
                    // Raise within the bound rules
                    case (r_edit_index)
                        L_TEMP_LOW: begin
                            if (r_temp_low < TEMP_BOUND_HI
                                && (7'(r_temp_low) + 7'd1) < 7'(r_temp_high)) begin
                                n_temp_low = r_temp_low + 6'd1;
                            end
                        end
                        L_TEMP_HIGH: begin
                            if (r_temp_high < TEMP_BOUND_HI) begin
                                n_temp_high = r_temp_high + 6'd1;
                            end
                        end
                        L_HUM_LOW: begin
                            if (r_hum_low < HUM_BOUND_HI
                                && (8'(r_hum_low) + 8'd1) < 8'(r_hum_high)) begin
                                n_hum_low = r_hum_low + 7'd1;
                            end
                        end
                        default: begin
                            if (r_hum_high < HUM_BOUND_HI) begin
                                n_hum_high = r_hum_high + 7'd1;
                            end
                        end
                    endcase
                end else if (n_debounce == '0 && n_edit_on && n_flags[B_DEC]) begin
                    n_debounce     = DebLoad;
                    n_flags[B_DEC] = 1'b0;
                    // Lower within the bound rules
                    case (r_edit_index)
                        L_TEMP_LOW: begin
                            if (r_temp_low != 6'd0) begin
                                n_temp_low = r_temp_low - 6'd1;
                            end
                        end
                        L_TEMP_HIGH: begin
                            if (r_temp_high != 6'd0
                                && (r_temp_high - 6'd1) > r_temp_low) begin
                                n_temp_high = r_temp_high - 6'd1;
                            end
                        end
                        L_HUM_LOW: begin
                            if (r_hum_low != 7'd0) begin
                                n_hum_low = r_hum_low - 7'd1;
                            end
                        end
                        default: begin
                            if (r_hum_high != 7'd0
                                && (r_hum_high - 7'd1) > r_hum_low) begin
                                n_hum_high = r_hum_high - 7'd1;
                            end
                        end
                    endcase
                end
            end
            K_SAMPLE: begin
                // Convert the raw codes to exact scaled integers
                n_temp_scaled = $signed({1'b0, temp_prod}) - TEMP_OFS_SCALED;
                n_hum_scaled  = 23'(i_raw_hum) * HUM_MUL;
            end
            default: begin
                if (alarm_t && alarm_h) begin
                    // Both out: restart the blink on entry
                    if (!r_blink_on) begin
                        n_blink_cycles = '0;
                        n_blink_phase  = 1'b0;
                        n_blink_start  = i_now_ms;
                    end
                    elapsed = i_now_ms - n_blink_start;
                    if (elapsed >= BLINK_MS) begin
                        n_blink_start = i_now_ms;
                        n_blink_phase = ~n_blink_phase;
                        if (!n_blink_phase) begin
                            n_blink_cycles = n_blink_cycles + CycW'(1);
                        end
                    end
                    n_lamp     = n_blink_phase ? 2'b01 : 2'b10;
                    n_blink_on = 1'b1;
                    // End the pattern after the last cycle
                    if (n_blink_cycles >= CycDone) begin
                        n_blink_on = 1'b0;
                        n_lamp     = 2'b00;
                    end
                end else begin
                    n_blink_on     = 1'b0;
                    n_blink_cycles = '0;
                    n_lamp         = {alarm_h, alarm_t};
                end
            end
        endcase
    end

    // Select the limit shown with the result
    always_comb begin
        case (n_edit_index)
            L_TEMP_LOW:  sel_value = 7'(n_temp_low);
            L_TEMP_HIGH: sel_value = 7'(n_temp_high);
            L_HUM_LOW:   sel_value = n_hum_low;
            default:     sel_value = n_hum_high;
        endcase
    end

    assign o_result.red_on         = n_lamp[0];
    assign o_result.blue_on        = n_lamp[1];
    assign o_result.editing        = n_edit_on;
    assign o_result.selected_limit = n_edit_index;
    assign o_result.selected_value = sel_value;

    // Commit the state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_scaled  <= '0;
            r_hum_scaled   <= '0;
            r_temp_low     <= TEMP_LOW_RST;
            r_temp_high    <= TEMP_HIGH_RST;
            r_hum_low      <= HUM_LOW_RST;
            r_hum_high     <= HUM_HIGH_RST;
            r_edit_on      <= 1'b0;
            r_edit_index   <= L_TEMP_LOW;
            r_debounce     <= '0;
            r_flags        <= '0;
            r_blink_on     <= 1'b0;
            r_blink_phase  <= 1'b0;
            r_blink_cycles <= '0;
            r_blink_start  <= '0;
            r_lamp         <= '0;
        end else if (i_accept) begin
            r_temp_scaled  <= n_temp_scaled;
            r_hum_scaled   <= n_hum_scaled;
            r_temp_low     <= n_temp_low;
            r_temp_high    <= n_temp_high;
            r_hum_low      <= n_hum_low;
            r_hum_high     <= n_hum_high;
            r_edit_on      <= n_edit_on;
            r_edit_index   <= n_edit_index;
            r_debounce     <= n_debounce;
            r_flags        <= n_flags;
            r_blink_on     <= n_blink_on;
            r_blink_phase  <= n_blink_phase;
            r_blink_cycles <= n_blink_cycles;
            r_blink_start  <= n_blink_start;
            r_lamp         <= n_lamp;
        end
    end

endmodule

/* sv/climate_limit_alarm_controller_top.sv */
// Climate limit alarm controller.
// Input channel (i_in_valid / o_in_stall): one request per accepted item; i_kind
// picks a button event, a 20 ms UI tick, a sensor sample or a LED tick with the
// millisecond time. Only the fields of that kind are looked at.
// Output channel (o_out_valid / i_out_stall): exactly one result per request,
// in order: lamp states, edit mode, selected limit and its value.
// The result of a request accepted at an edge is offered right after that edge
// when the output register is free, so it can be taken at the next edge.
// Throughput: one request per cycle while o_in_stall is low; the whole update is a
// single registered pass through the core.
// A two-entry output (result register plus skid register) lets a request be
// taken while the previous result still waits; o_in_stall rises only when
// both entries hold results, and drops once the receiver takes one.
// While i_out_stall is high the shown result holds unchanged.
// Reset (i_rst_n low, synchronous) empties the output, restores the default
// limits 18/24 degrees and 30/60 percent, leaves edit mode and turns both
// lamps off; the stored sample reads 0 degrees and 0 percent until the first
// sample arrives.
module climate_limit_alarm_controller_top #(
    parameter int DEBOUNCE_TICKS = clac_pkg::DEBOUNCE_TICKS_DEF,
    parameter int BLINK_CYCLES   = clac_pkg::BLINK_CYCLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_button,
    input  logic        i_return_held,
    input  logic [15:0] i_raw_temp,
    input  logic [15:0] i_raw_hum,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_red_on,
    output logic        o_blue_on,
    output logic        o_editing,
    output logic [1:0]  o_selected_limit,
    output logic [6:0]  o_selected_value
);
    import clac_pkg::*;

    logic    in_accept;
    logic    out_take;
    t_result next_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_out_stall;

    clac_core #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
        .BLINK_CYCLES   (BLINK_CYCLES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_kind        (i_kind),
        .i_button      (i_button),
        .i_return_held (i_return_held),
        .i_raw_temp    (i_raw_temp),
        .i_raw_hum     (i_raw_hum),
        .i_now_ms      (i_now_ms),
        .o_result      (next_result)
    );

    // Output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : next_result;
        end else if (in_accept) begin
            r_skid <= next_result;
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_red_on         = r_out.red_on;
    assign o_blue_on        = r_out.blue_on;
    assign o_editing        = r_out.editing;
    assign o_selected_limit = r_out.selected_limit;
    assign o_selected_value = r_out.selected_value;

endmodule

/* sv/clac_checker.sv */
`include "climate_limit_alarm_controller_top_defines.svh"

module clac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_red_on,
    input logic        o_blue_on,
    input logic        o_editing,
    input logic [1:0]  o_selected_limit,
    input logic [6:0]  o_selected_value
);

    logic [11:0] shown_bits;

    assign shown_bits = {o_red_on, o_blue_on, o_editing, o_selected_limit, o_selected_value};

    // A stalled result stays offered
    `CLAC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its value
    `CLAC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(shown_bits))

    // A request taken while the output is empty shows up at the next edge
    `CLAC_ASSERT_NEXT(a_latency, i_in_valid && !o_in_stall && !o_out_valid, o_out_valid)

    // Never both lamps at once, and the shown limit stays in range
    `CLAC_ASSERT_SAME(a_lamps_range, o_out_valid, !(o_red_on && o_blue_on) && o_selected_value <= 7'd100)

endmodule

bind climate_limit_alarm_controller_top clac_checker u_clac_checker (.*);

/* tb/sv/climate_limit_alarm_controller_top_test.sv */
module climate_limit_alarm_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clac_pkg::*;

    // Block tuning, also passed to the instance
    localparam int DEBOUNCE_TICKS = 50;
    localparam int BLINK_CYCLES   = 5;

    // Fixed-point conversion: values are kept as degrees*65535 and percent*65535
    localparam int SCALE       = 65535;
    localparam int TEMP_GAIN   = 175;
    localparam int TEMP_OFFSET = 45 * 65535;
    localparam int HUM_GAIN    = 100;

    // Limit bounds and blink timing
    localparam int          TEMP_LIMIT_MAX = 40;
    localparam int          HUM_LIMIT_MAX  = 100;
    localparam logic [31:0] BLINK_HALF_MS  = 32'd200;
    localparam logic [1:0]  BTN_UNUSED     = 2'd3;

    // Run control
    localparam int          RESET_CYCLES   = 7;
    localparam int          RANDOM_TARGET  = 1520;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT    = 200_000;
    localparam int          SEND_IDLE_FIRST = 26;
    localparam int          RECV_IDLE_FIRST = 55;
    localparam int          SEND_IDLE_NEXT  = 55;
    localparam int          RECV_IDLE_NEXT  = 26;

    // Raw code windows: inside the default limits, and clearly below/above them
    localparam int TEMP_IN_LO = 23593;
    localparam int TEMP_IN_HI = 25839;
    localparam int HUM_IN_LO  = 19661;
    localparam int HUM_IN_HI  = 39321;
    localparam int TEMP_COLD  = 20000;
    localparam int HUM_DAMP   = 45000;

    typedef struct {
        t_kind       kind;
        logic [1:0]  button;
        logic        ret_held;
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
        logic [31:0] now_ms;
        bit          drain;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = '0;
    logic [1:0]  i_button = '0;
    logic        i_return_held = 1'b0;
    logic [15:0] i_raw_temp = '0;
    logic [15:0] i_raw_hum = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_red_on;
    logic        o_blue_on;
    logic        o_editing;
    logic [1:0]  o_selected_limit;
    logic [6:0]  o_selected_value;

    t_request    request_q[$];
    t_result     expected_panel_q[$];
    t_request    cur_req;
    t_result     model_panel;
    t_result     seen_panel;
    t_result     want_panel;

    int          total_requests = 0;
    int          issued_cnt = 0;
    int          requests_taken = 0;
    int          panels_seen = 0;
    int          err_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_cnt = 0;
    logic [31:0] ms_clock = '0;

    // Model of the panel state
    logic signed [24:0] temp_fx = '0;
    logic [22:0]        hum_fx = '0;
    logic [5:0]         t_lo_lim = 6'd18;
    logic [5:0]         t_hi_lim = 6'd24;
    logic [6:0]         h_lo_lim = 7'd30;
    logic [6:0]         h_hi_lim = 7'd60;
    logic               in_edit = 1'b0;
    logic [1:0]         sel = '0;
    logic [5:0]         debounce = '0;
    logic [2:0]         presses = '0;
    logic               blinking = 1'b0;
    logic               blink_ph = 1'b0;
    logic [2:0]         blink_cnt = '0;
    logic [31:0]        blink_t0 = '0;
    logic [1:0]         lamps = '0;

    climate_limit_alarm_controller_top #(
        .DEBOUNCE_TICKS(DEBOUNCE_TICKS),
        .BLINK_CYCLES(BLINK_CYCLES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_button(i_button),
        .i_return_held(i_return_held),
        .i_raw_temp(i_raw_temp),
        .i_raw_hum(i_raw_hum),
        .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_red_on(o_red_on),
        .o_blue_on(o_blue_on),
        .o_editing(o_editing),
        .o_selected_limit(o_selected_limit),
        .o_selected_value(o_selected_value)
    );

    // Advance the panel model by one request and return the shown state
    task automatic compute_panel_state(input t_request r, output t_result res);
        bit         alarm_t;
        bit         alarm_h;
        logic [6:0] shown;
        case (r.kind)
            K_BUTTON: begin
                if (r.button != BTN_UNUSED)
                    presses[r.button] = 1'b1;
            end
            K_UI_TICK: begin
                if (debounce != 0)
                    debounce = debounce - 6'd1;
                // return key: leave edit mode, drop flags, reload debounce
                if (r.ret_held) begin
                    in_edit = 1'b0;
                    presses = '0;
                    debounce = 6'(DEBOUNCE_TICKS);
                end
                if (debounce == 0 && presses[B_NEXT]) begin
                    in_edit = 1'b1;
                    sel = sel + 2'd1;
                    debounce = 6'(DEBOUNCE_TICKS);
                    presses[B_NEXT] = 1'b0;
                end
                // raise the selected limit within its bound rules
                if (debounce == 0 && in_edit && presses[B_INC]) begin
                    case (sel)
                        L_TEMP_LOW: begin
                            if (int'(t_lo_lim) < TEMP_LIMIT_MAX &&
                                int'(t_lo_lim) + 1 < int'(t_hi_lim))
                                t_lo_lim = t_lo_lim + 6'd1;
                        end
                        L_TEMP_HIGH: begin
                            if (int'(t_hi_lim) < TEMP_LIMIT_MAX)
                                t_hi_lim = t_hi_lim + 6'd1;
                        end
                        L_HUM_LOW: begin
                            if (int'(h_lo_lim) < HUM_LIMIT_MAX &&
                                int'(h_lo_lim) + 1 < int'(h_hi_lim))
                                h_lo_lim = h_lo_lim + 7'd1;
                        end
                        default: begin
                            if (int'(h_hi_lim) < HUM_LIMIT_MAX)
                                h_hi_lim = h_hi_lim + 7'd1;
                        end
                    endcase
                    debounce = 6'(DEBOUNCE_TICKS);
                    presses[B_INC] = 1'b0;
                end
                // lower the selected limit within its bound rules
                if (debounce == 0 && in_edit && presses[B_DEC]) begin
                    case (sel)
                        L_TEMP_LOW: begin
                            if (t_lo_lim != 0)
                                t_lo_lim = t_lo_lim - 6'd1;
                        end
                        L_TEMP_HIGH: begin
                            if (t_hi_lim != 0 && int'(t_hi_lim) - 1 > int'(t_lo_lim))
                                t_hi_lim = t_hi_lim - 6'd1;
                        end
                        L_HUM_LOW: begin
                            if (h_lo_lim != 0)
                                h_lo_lim = h_lo_lim - 7'd1;
                        end
                        default: begin
                            if (h_hi_lim != 0 && int'(h_hi_lim) - 1 > int'(h_lo_lim))
                                h_hi_lim = h_hi_lim - 7'd1;
                        end
                    endcase
                    debounce = 6'(DEBOUNCE_TICKS);
                    presses[B_DEC] = 1'b0;
                end
            end
            K_SAMPLE: begin
                temp_fx = 25'(TEMP_GAIN * int'(r.raw_temp) - TEMP_OFFSET);
                hum_fx = 23'(HUM_GAIN * int'(r.raw_hum));
            end
            default: begin
                alarm_t = temp_fx < int'(t_lo_lim) * SCALE || temp_fx > int'(t_hi_lim) * SCALE;
                alarm_h = int'(hum_fx) < int'(h_lo_lim) * SCALE ||
                          int'(hum_fx) > int'(h_hi_lim) * SCALE;
                if (alarm_t && alarm_h) begin
                    // both out: alternate the lamps, stop after the cycle budget
                    if (!blinking) begin
                        blinking = 1'b1;
                        blink_cnt = '0;
                        blink_ph = 1'b0;
                        blink_t0 = r.now_ms;
                    end
                    if (r.now_ms - blink_t0 >= BLINK_HALF_MS) begin
                        blink_t0 = r.now_ms;
                        blink_ph = ~blink_ph;
                        if (!blink_ph)
                            blink_cnt = blink_cnt + 3'd1;
                    end
                    lamps = blink_ph ? 2'b01 : 2'b10;
                    if (int'(blink_cnt) >= BLINK_CYCLES) begin
                        blinking = 1'b0;
                        lamps = 2'b00;
                    end
                end else begin
                    blinking = 1'b0;
                    blink_cnt = '0;
                    lamps = {alarm_h, alarm_t};
                end
            end
        endcase
        case (sel)
            L_TEMP_LOW:  shown = {1'b0, t_lo_lim};
            L_TEMP_HIGH: shown = {1'b0, t_hi_lim};
            L_HUM_LOW:   shown = h_lo_lim;
            default:     shown = h_hi_lim;
        endcase
        res.red_on = lamps[0];
        res.blue_on = lamps[1];
        res.editing = in_edit;
        res.selected_limit = t_limit_sel'(sel);
        res.selected_value = shown;
    endtask

    // Queue one request; fields the kind does not use get random values
    task automatic push_req(input t_kind k, input logic [1:0] b, input logic ret,
                            input logic [15:0] rt, input logic [15:0] rh,
                            input logic [31:0] now);
        t_request r;
        r.kind = k;
        r.button = 2'($urandom_range(3));
        r.ret_held = 1'($urandom_range(1));
        r.raw_temp = 16'($urandom);
        r.raw_hum = 16'($urandom);
        r.now_ms = $urandom;
        r.drain = ($urandom_range(99) == 0);
        case (k)
            K_BUTTON:  r.button = b;
            K_UI_TICK: r.ret_held = ret;
            K_SAMPLE: begin
                r.raw_temp = rt;
                r.raw_hum = rh;
            end
            default:   r.now_ms = now;
        endcase
        request_q.push_back(r);
    endtask

    task automatic led_after(input int unsigned step);
        ms_clock = ms_clock + step;
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, ms_clock);
    endtask

    // Sensor sample biased toward in-band, out-of-band and both-out readings
    task automatic random_sample();
        logic [15:0] rt;
        logic [15:0] rh;
        case ($urandom_range(3))
            0: begin
                rt = 16'($urandom);
                rh = 16'($urandom);
            end
            1: begin
                rt = 16'($urandom_range(TEMP_IN_HI, TEMP_IN_LO));
                rh = 16'($urandom_range(HUM_IN_HI, HUM_IN_LO));
            end
            2: begin
                rt = 16'($urandom_range(TEMP_COLD, 0));
                rh = 16'($urandom_range(65535, HUM_DAMP));
            end
            default: begin
                rt = 16'($urandom_range(TEMP_IN_HI, TEMP_IN_LO));
                rh = 16'($urandom);
            end
        endcase
        push_req(K_SAMPLE, '0, 1'b0, rt, rh, '0);
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Request driver: take accepted requests into the model, present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                compute_panel_state(cur_req, model_panel);
                expected_panel_q.push_back(model_panel);
                requests_taken++;
            end
            if (issued_cnt < total_requests / 3)
                send_idle_pct = SEND_IDLE_FIRST;
            else if (issued_cnt < 2 * total_requests / 3)
                send_idle_pct = SEND_IDLE_NEXT;
            else
                send_idle_pct = 0;
            recv_idle_pct <= (issued_cnt < total_requests / 3) ? RECV_IDLE_FIRST :
                             (issued_cnt < 2 * total_requests / 3) ? RECV_IDLE_NEXT : 0;
            // hold a stalled request; otherwise load the next one or idle
            if (!(i_in_valid && o_in_stall)) begin
                if (request_q.size() != 0 &&
                    !(request_q[0].drain && requests_taken != panels_seen) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_req = request_q.pop_front();
                    issued_cnt++;
                    i_kind <= cur_req.kind;
                    i_button <= cur_req.button;
                    i_return_held <= cur_req.ret_held;
                    i_raw_temp <= cur_req.raw_temp;
                    i_raw_hum <= cur_req.raw_hum;
                    i_now_ms <= cur_req.now_ms;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_panel = {o_red_on, o_blue_on, o_editing, o_selected_limit,
                              o_selected_value};
                if (expected_panel_q.size() == 0) begin
                    $display("%0t: unexpected result red=%b blue=%b edit=%b limit=%0d value=%0d",
                             $time, seen_panel.red_on, seen_panel.blue_on,
                             seen_panel.editing, seen_panel.selected_limit,
                             seen_panel.selected_value);
                    err_cnt++;
                end else begin
                    want_panel = expected_panel_q.pop_front();
                    if (seen_panel !== want_panel) begin
                        $display("%0t: #%0d expected red=%b blue=%b edit=%b lim=%0d val=%0d",
                                 $time, panels_seen, want_panel.red_on, want_panel.blue_on,
                                 want_panel.editing, want_panel.selected_limit,
                                 want_panel.selected_value);
                        $display("%0t: #%0d actual   red=%b blue=%b edit=%b lim=%0d val=%0d",
                                 $time, panels_seen, seen_panel.red_on, seen_panel.blue_on,
                                 seen_panel.editing, seen_panel.selected_limit,
                                 seen_panel.selected_value);
                        err_cnt++;
                    end
                    panels_seen <= panels_seen + 1;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(negedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int         pick;
        int         n;
        int         c;
        bit         dir_up;
        logic [1:0] btn;

        // Directed: reset sample, blink entry and toggle, ignored and latched buttons
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd0);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd199);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd200);
        push_req(K_BUTTON, BTN_UNUSED, 1'b0, '0, '0, '0);
        push_req(K_BUTTON, B_INC, 1'b0, '0, '0, '0);
        push_req(K_UI_TICK, '0, 1'b0, '0, '0, '0);
        push_req(K_UI_TICK, '0, 1'b1, '0, '0, '0);
        push_req(K_BUTTON, B_NEXT, 1'b0, '0, '0, '0);
        push_req(K_UI_TICK, '0, 1'b0, '0, '0, '0);
        push_req(K_BUTTON, B_DEC, 1'b0, '0, '0, '0);
        // Directed: sample extremes, exact limit values and time wraparound
        push_req(K_SAMPLE, '0, 1'b0, 16'h0000, 16'h0000, '0);
        push_req(K_SAMPLE, '0, 1'b0, 16'hFFFF, 16'hFFFF, '0);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'hFFFF_FFFF);
        push_req(K_SAMPLE, '0, 1'b0, 16'd26214, 16'd39321, '0);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd0);
        push_req(K_SAMPLE, '0, 1'b0, 16'd26214, 16'd39322, '0);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd5);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd204);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd205);
        push_req(K_SAMPLE, '0, 1'b0, 16'd23593, 16'd19660, '0);
        push_req(K_LED_TICK, '0, 1'b0, '0, '0, 32'd300);
        push_req(K_UI_TICK, '0, 1'b1, '0, '0, '0);

        // Random: mostly button actions followed by a full debounce of UI ticks
        ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(40000));
        dir_up = 1'b1;
        while (request_q.size() < RANDOM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_req(t_kind'($urandom_range(3)), 2'($urandom_range(3)),
                         1'($urandom_range(1)), 16'($urandom), 16'($urandom), $urandom);
            end else if (pick < 20) begin
                // blink run: both out, then a train of LED ticks
                if ($urandom_range(3) != 0)
                    push_req(K_SAMPLE, '0, 1'b0, 16'($urandom_range(TEMP_COLD, 0)),
                             16'($urandom_range(65535, HUM_DAMP)), '0);
                n = $urandom_range(30, 8);
                repeat (n) led_after($urandom_range(260, 40));
            end else begin
                if ($urandom_range(99) < 15)
                    dir_up = !dir_up;
                c = $urandom_range(99);
                if (c < 22)
                    btn = B_NEXT;
                else if (c < 25)
                    btn = BTN_UNUSED;
                else
                    btn = dir_up ? B_INC : B_DEC;
                push_req(K_BUTTON, btn, 1'b0, '0, '0, '0);
                if ($urandom_range(99) < 10)
                    push_req(K_BUTTON, 2'($urandom_range(3)), 1'b0, '0, '0, '0);
                n = ($urandom_range(99) < 85) ? DEBOUNCE_TICKS + 1
                                              : $urandom_range(DEBOUNCE_TICKS + 5);
                repeat (n) begin
                    push_req(K_UI_TICK, '0, ($urandom_range(199) == 0), '0, '0, '0);
                    c = $urandom_range(99);
                    if (c < 10)
                        led_after($urandom_range(300));
                    else if (c < 13)
                        random_sample();
                end
            end
        end
        total_requests = request_q.size();
        // drain the block between idle phases
        request_q[total_requests / 3].drain = 1'b1;
        request_q[2 * total_requests / 3].drain = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_in_valid || requests_taken != panels_seen)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_cnt == 0 && expected_panel_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
